### rtl/restoring_divider_u16_unit_assert.svh
// Assertion macros for the divider checker.
`ifndef RESTORING_DIVIDER_U16_UNIT_ASSERT_SVH
`define RESTORING_DIVIDER_U16_UNIT_ASSERT_SVH

// Clocked check, held off while in reset.
`define RDU16_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also runs while in reset.
`define RDU16_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rdu16_pkg.sv
`default_nettype none

package rdu16_pkg;

	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage

`default_nettype wire

### rtl/restoring_divider_u16_unit.sv
// Channel | Handshake           | Payload
// in      | in_valid / in_stall | dividend, divisor
// out     | out_valid/out_stall | quotient
//
// One pipeline stage per quotient bit: DATA_WIDTH stages, one shift-and-subtract each.
// Each beat is registered once per stage on its way to the output; one beat per cycle while out_stall is low.
// Reset clears every stage valid bit; no result is held over.
// A stalled output holds the last stage; bubbles still close up behind it.
// in_stall rises only when every stage holds a beat and out_stall is high.
`default_nettype none

module restoring_divider_u16_unit #(
	parameter int DATA_WIDTH = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire  [DATA_WIDTH-1:0] dividend,
	input  wire  [DATA_WIDTH-1:0] divisor,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic [DATA_WIDTH-1:0] quotient
);
	import rdu16_pkg::*;

	logic [DATA_WIDTH:0]                 valid_c;
	logic [DATA_WIDTH:0]                 ready_c;
	logic [DATA_WIDTH:0][DATA_WIDTH-1:0] rem_c;
	logic [DATA_WIDTH:0][DATA_WIDTH-1:0] nq_c;
	logic [DATA_WIDTH:0][DATA_WIDTH-1:0] den_c;
	hs_t  [DATA_WIDTH-1:0]               hs_c;

	assign valid_c[0] = in_valid;
	assign rem_c[0]   = '0;
	assign nq_c[0]    = dividend;
	assign den_c[0]   = divisor;

	for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_stage
		rdu16_stage #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.valid_i(valid_c[g]),
			.ready_o(ready_c[g]),
			.rem_i  (rem_c[g]),
			.nq_i   (nq_c[g]),
			.den_i  (den_c[g]),
			.hs_o   (hs_c[g]),
			.ready_i(ready_c[g+1]),
			.rem_o  (rem_c[g+1]),
			.nq_o   (nq_c[g+1]),
			.den_o  (den_c[g+1])
		);
		assign valid_c[g+1] = hs_c[g].valid;
	end

	assign ready_c[DATA_WIDTH] = ~out_stall;

	assign in_stall  = ~hs_c[0].ready;
	assign out_valid = valid_c[DATA_WIDTH];
	assign quotient  = nq_c[DATA_WIDTH];

endmodule

`default_nettype wire

### rtl/rdu16_stage.sv
`default_nettype none

module rdu16_stage #(
	parameter int DATA_WIDTH = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   valid_i,
	output logic                  ready_o,
	input  wire  [DATA_WIDTH-1:0] rem_i,
	input  wire  [DATA_WIDTH-1:0] nq_i,
	input  wire  [DATA_WIDTH-1:0] den_i,
	output rdu16_pkg::hs_t        hs_o,
	input  wire                   ready_i,
	output logic [DATA_WIDTH-1:0] rem_o,
	output logic [DATA_WIDTH-1:0] nq_o,
	output logic [DATA_WIDTH-1:0] den_o
);
	import rdu16_pkg::*;

	logic                  valid_s;
	logic [DATA_WIDTH-1:0] rem_s;
	logic [DATA_WIDTH-1:0] nq_s;
	logic [DATA_WIDTH-1:0] den_s;

	logic [DATA_WIDTH-1:0] shifted;
	logic [DATA_WIDTH-1:0] diff;
	logic                  borrow;
	logic                  take;

	always_comb begin
		shifted        = {rem_i[DATA_WIDTH-2:0], nq_i[DATA_WIDTH-1]};
		{borrow, diff} = {1'b0, shifted} - {1'b0, den_i};
		take           = rem_i[DATA_WIDTH-1] | ~borrow;
	end

	assign ready_o = ~valid_s | ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (ready_o) begin
			valid_s <= valid_i;
		end
	end

	// advance payload only with a live beat
	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			rem_s <= take ? diff : shifted;
			nq_s  <= {nq_i[DATA_WIDTH-2:0], take};
			den_s <= den_i;
		end
	end

	always_comb begin
		hs_o.valid = valid_s;
		hs_o.ready = ready_o;
	end

	assign rem_o = rem_s;
	assign nq_o  = nq_s;
	assign den_o = den_s;

endmodule

`default_nettype wire

### rtl/rdu16_checker.sv
`default_nettype none

module rdu16_checker #(
	parameter int DATA_WIDTH = 16
) (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  in_valid,
	input wire                  in_stall,
	input wire [DATA_WIDTH-1:0] dividend,
	input wire [DATA_WIDTH-1:0] divisor,
	input wire                  out_valid,
	input wire                  out_stall,
	input wire [DATA_WIDTH-1:0] quotient
);
`include "restoring_divider_u16_unit_assert.svh"

	`RDU16_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(quotient), "stalled result beat changed")
	`RDU16_ASSERT(a_in_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without output backpressure")
	`RDU16_ASSERT(a_free_flow, !out_stall |-> !in_stall, "input stalled while output drains")
	`RDU16_ASSERT_RST(a_reset_empty, !arst_n |-> !out_valid && !in_stall, "pipeline not empty in reset")

endmodule

bind restoring_divider_u16_unit rdu16_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_rdu16_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.dividend (dividend),
	.divisor  (divisor),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.quotient (quotient)
);

`default_nettype wire
